// File: rtl/pfsd_pkg.sv
`timescale 1ns / 1ps

package pfsd_pkg;

  // Store geometry
  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int RESULT_W = 33;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_ORDER  = 2'd1;
  localparam logic [1:0] REG_DOUBLE = 2'd2;

  // Filter codes
  localparam logic [1:0] FILT_ALL  = 2'd0;
  localparam logic [1:0] FILT_EVEN = 2'd1;
  localparam logic [1:0] FILT_ODD  = 2'd2;

  // Order codes
  localparam logic [1:0] ORD_ARRIVAL = 2'd0;
  localparam logic [1:0] ORD_ASC     = 2'd1;
  localparam logic [1:0] ORD_DESC    = 2'd2;

  typedef struct packed {
    logic [1:0] filter_mode;
    logic [1:0] order_mode;
    logic       double_enable;
  } pfsd_cfg_t;

  // Keep decision for one incoming item
  function automatic logic pfsd_keep(input logic [1:0] mode,
                                     input logic [VALUE_W-1:0] v);
    logic keep;
    case (mode)
      FILT_EVEN: keep = (v != '0) && !v[0];
      FILT_ODD:  keep = v[0];
      default:   keep = 1'b1;
    endcase
    return keep;
  endfunction

endpackage

// File: rtl/pfsd_cfg.sv
`timescale 1ns / 1ps

module pfsd_cfg import pfsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output pfsd_cfg_t         cfg_o
);

  logic [1:0] filter_r;
  logic [1:0] order_r;
  logic       double_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];

  // Update registers on the access phase of a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= FILT_ALL;
      order_r  <= ORD_ARRIVAL;
      double_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FILTER: filter_r <= cfg_pwdata[1:0];
        REG_ORDER:  order_r  <= cfg_pwdata[1:0];
        REG_DOUBLE: double_r <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_FILTER: cfg_prdata = {{(CFG_DW-2){1'b0}}, filter_r};
      REG_ORDER:  cfg_prdata = {{(CFG_DW-2){1'b0}}, order_r};
      REG_DOUBLE: cfg_prdata = {{(CFG_DW-1){1'b0}}, double_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_o = '{filter_mode: filter_r, order_mode: order_r, double_enable: double_r};

endmodule

// File: rtl/pfsd_core.sv
`timescale 1ns / 1ps

module pfsd_core import pfsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pfsd_cfg_t           cfg_i,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] out_value,
  output logic                out_last,
  output logic                out_ovf
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KEY_RD,
    ST_KEY_WAIT,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Item store: one write and one registered read per cycle
  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] rdata_r;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic                      re;
  logic [IDX_W-1:0]          raddr;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic [CNT_W-1:0]          i_r, i_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic [CNT_W-1:0]          k_r, k_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      desc_r, desc_nxt;
  logic                      dbl_r, dbl_nxt;
  logic                      run_ovf_r, run_ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]       out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      accept;
  logic                      keep;
  logic                      ooo;
  logic [CNT_W-1:0]          i_m1;
  logic [CNT_W-1:0]          i_p1;
  logic [CNT_W-1:0]          k_p1;
  logic [IDX_W-1:0]          j_m1;
  logic [IDX_W-1:0]          j_m2;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign keep     = pfsd_keep(cfg_i.filter_mode, in_value);
  assign ooo      = desc_r ? (rdata_r < key_r) : (rdata_r > key_r);
  assign i_m1     = i_r - CNT_W'(1);
  assign i_p1     = i_r + CNT_W'(1);
  assign k_p1     = k_r + CNT_W'(1);
  assign j_m1     = j_r - IDX_W'(1);
  assign j_m2     = j_r - IDX_W'(2);

  // Store access
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Sequencer: load, insertion sort in place, emit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    key_nxt       = key_r;
    desc_nxt      = desc_r;
    dbl_nxt       = dbl_r;
    run_ovf_nxt   = run_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = in_value;
    re            = 1'b0;
    raddr         = '0;

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          // Store a kept item, or flag it when the store is full
          if (keep && (cnt_r < CNT_W'(MAX_ITEMS))) begin
            we      = 1'b1;
            waddr   = cnt_r[IDX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (keep) begin
            ovf_nxt = 1'b1;
          end
          // Close the run and sample the output options
          if (in_last) begin
            n_nxt       = cnt_nxt;
            run_ovf_nxt = ovf_nxt;
            desc_nxt    = (cfg_i.order_mode == ORD_DESC);
            dbl_nxt     = cfg_i.double_enable;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            i_nxt       = CNT_W'(1);
            k_nxt       = '0;
            if (n_nxt == '0) begin
              state_nxt = ST_LOAD;
            end else if ((cfg_i.order_mode inside {ORD_ASC, ORD_DESC}) &&
                         (n_nxt > CNT_W'(1))) begin
              state_nxt = ST_KEY_RD;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end
      ST_KEY_RD: begin
        re        = 1'b1;
        raddr     = i_r[IDX_W-1:0];
        state_nxt = ST_KEY_WAIT;
      end
      ST_KEY_WAIT: begin
        key_nxt   = rdata_r;
        j_nxt     = i_r[IDX_W-1:0];
        re        = 1'b1;
        raddr     = i_m1[IDX_W-1:0];
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = j_r;
        if (ooo) begin
          // Move the neighbor up and look one further down
          wdata = rdata_r;
          j_nxt = j_m1;
          if (j_r == IDX_W'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = j_m2;
          end
        end else begin
          wdata = key_r;
          i_nxt = i_p1;
          state_nxt = (i_p1 == n_r) ? ST_EMIT_RD : ST_KEY_RD;
        end
      end
      ST_PLACE: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = key_r;
        i_nxt     = i_p1;
        state_nxt = (i_p1 == n_r) ? ST_EMIT_RD : ST_KEY_RD;
      end
      ST_EMIT_RD: begin
        // Fetch the next result once the output register frees up
        if (!out_valid_r || out_ready) begin
          re        = 1'b1;
          raddr     = k_r[IDX_W-1:0];
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = dbl_r ? {rdata_r, 1'b0} : {rdata_r[VALUE_W-1], rdata_r};
        out_last_nxt  = (k_p1 == n_r);
        out_ovf_nxt   = run_ovf_r;
        k_nxt         = k_p1;
        state_nxt     = (k_p1 == n_r) ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    key_r       <= key_nxt;
    desc_r      <= desc_nxt;
    dbl_r       <= dbl_nxt;
    run_ovf_r   <= run_ovf_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  // Fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond store depth");

  // A shift step always has a lower neighbor to compare against
  a_shift_j: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> j_r != '0)
    else $error("shift step at bottom of store");

  // Sort key index stays inside the run
  a_sort_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEY_RD || state_r == ST_KEY_WAIT) |-> (i_r < n_r && i_r != '0))
    else $error("sort key index out of run");

  // Loading the final result returns the sequencer to load
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && k_p1 == n_r) |=> state_r == ST_LOAD && out_last_r)
    else $error("run did not close after final result");

  // The emit fetch is only issued into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_LD |-> !out_valid_r)
    else $error("result fetched into a busy output register");

endmodule

// File: rtl/parity_filter_sort_double.sv
`timescale 1ns / 1ps

// Channel  Dir  Signals                        Contents
// in_      in   in_tvalid/tready/tdata/tlast   tdata[31:0] item_value, tlast item_last
// out_     out  out_tvalid/tready/tdata/tlast  tdata[32:0] result_value, tlast result_last,
//                /tuser                        tuser run_overflowed
// cfg_     in   APB psel/penable/pwrite/paddr  0x0 filter_mode, 0x4 order_mode,
//                /pwdata/prdata/pready         0x8 double_enable
//
// Loading takes one item per cycle while in load; in_tready is low otherwise. After the last
// item of a run with n kept items the store is sorted in place by insertion, bound by its
// single read port. Emission then moves each result from the store to the output register.
// Arrival order skips the sort. Reset (rst_n, synchronous) clears control state only; the
// store needs no clearing pass. A stalled output holds the sequencer in emission.

module parity_filter_sort_double import pfsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] item_value
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // [32:0] result_value, [39:33] zero
  output logic              out_tlast,
  output logic              out_tuser,  // [0] run_overflowed
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  pfsd_cfg_t           cfg;
  logic [RESULT_W-1:0] result_value;

  pfsd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  pfsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata[VALUE_W-1:0]),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (result_value),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

  // Pad the result to whole bytes
  assign out_tdata = {{(40-RESULT_W){1'b0}}, result_value};

endmodule

// File: tb/tb_parity_filter_sort_double.sv
`timescale 1ns / 1ps

module tb_parity_filter_sort_double;
  import pfsd_pkg::*;

  // Codes the block must treat as defaults, and the register index it must ignore
  localparam logic [1:0] FILT_SPARE = 2'd3;
  localparam logic [1:0] ORD_SPARE  = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  localparam int RANDOM_ITEMS  = 250;
  localparam int SETTLE_CYCLES = 100;
  localparam int IDLE_PCT      = 36;
  localparam int MAX_PRINTS    = 30;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } item_t;

  typedef struct {
    logic [32:0] value;
    logic        last;
    logic        overflowed;
  } result_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;   // [31:0] item_value
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [39:0]       out_tdata;  // [32:0] result_value, [39:33] zero
  logic              out_tlast;
  logic              out_tuser;  // [0] run_overflowed
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  item_t              pending_items[$];
  result_t            expected_results[$];
  logic signed [31:0] held_items[$];
  logic               held_overflow;
  pfsd_cfg_t          cfg_shadow;
  logic               in_fire;
  logic               steady;
  int                 errors;
  int                 item_count;

  parity_filter_sort_double uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic [31:0] register_value(input logic [1:0] idx);
    logic [31:0] v;
    v = '0;
    case (idx)
      REG_FILTER: v[1:0] = cfg_shadow.filter_mode;
      REG_ORDER:  v[1:0] = cfg_shadow.order_mode;
      REG_DOUBLE: v[0]   = cfg_shadow.double_enable;
      default:    v      = '0;
    endcase
    return v;
  endfunction

  function automatic void update_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_FILTER: cfg_shadow.filter_mode   = data[1:0];
      REG_ORDER:  cfg_shadow.order_mode    = data[1:0];
      REG_DOUBLE: cfg_shadow.double_enable = data[0];
      default:    ;
    endcase
  endfunction

  // Filter one item into the run; on the last item order, scale and queue the burst
  function automatic void absorb_item(input logic [31:0] raw, input logic last);
    logic signed [31:0] v;
    logic signed [31:0] ordered[$];
    logic signed [31:0] key;
    logic               keep;
    logic               swap;
    int                 j;
    result_t            r;
    v = raw;
    case (cfg_shadow.filter_mode)
      FILT_EVEN: keep = (v != 0) && (v[0] == 1'b0);
      FILT_ODD:  keep = v[0];
      default:   keep = 1'b1;
    endcase
    if (keep) begin
      if (held_items.size() < MAX_ITEMS)
        held_items.push_back(v);
      else
        held_overflow = 1'b1;
    end
    if (!last) return;

    ordered = held_items;
    if (cfg_shadow.order_mode == ORD_ASC || cfg_shadow.order_mode == ORD_DESC) begin
      for (int i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i;
        swap = 1'b1;
        while (j > 0 && swap) begin
          swap = (cfg_shadow.order_mode == ORD_ASC) ? (ordered[j-1] > key)
                                                    : (ordered[j-1] < key);
          if (swap) begin
            ordered[j] = ordered[j-1];
            j--;
          end
        end
        ordered[j] = key;
      end
    end

    for (int i = 0; i < ordered.size(); i++) begin
      r.value      = cfg_shadow.double_enable ? {ordered[i], 1'b0}
                                              : {ordered[i][31], ordered[i]};
      r.last       = (i == ordered.size() - 1);
      r.overflowed = held_overflow;
      expected_results.push_back(r);
    end
    held_items.delete();
    held_overflow = 1'b0;
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      cfg_shadow = '0;
      held_items.delete();
      held_overflow = 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        absorb_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected", 64'(out_tdata), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[32:0] !== want.value)
            report_mismatch("result_value", 64'(out_tdata[32:0]), 64'(want.value));
          if (out_tlast !== want.last)
            report_mismatch("result_last", 64'(out_tlast), 64'(want.last));
          if (out_tuser !== want.overflowed)
            report_mismatch("run_overflowed", 64'(out_tuser), 64'(want.overflowed));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite)
          update_register(cfg_paddr[3:2], cfg_pwdata);
        else if (cfg_prdata !== register_value(cfg_paddr[3:2]))
          report_mismatch("register readback", 64'(cfg_prdata),
                          64'(register_value(cfg_paddr[3:2])));
      end
    end
  end

  // Present pending items and the output stall at the falling edge
  always @(negedge clk) begin : driver
    if (in_fire)
      pending_items.delete(0);
    // hold an offered item until it is taken
    if (!(in_tvalid && !in_fire)) begin
      if (pending_items.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_items[0].value;
        in_tlast  <= pending_items[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic add_item(input logic [31:0] value, input logic last);
    item_t it;
    it.value = value;
    it.last  = last;
    pending_items.push_back(it);
    item_count++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       s = 32'h0000_0000;
          1:       s = 32'h0000_0001;
          2:       s = 32'hFFFF_FFFF;
          3:       s = 32'h8000_0000;
          default: s = 32'h7FFF_FFFF;
        endcase
      end
      1, 2, 3: begin
        // narrow range so duplicates reach the sort
        s = $urandom_range(40);
        s = s - 32'd20;
      end
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic queue_run(input int len, input logic close);
    for (int i = 0; i < len; i++)
      add_item(pick_value(), close && (i == len - 1));
  endtask

  task automatic cfg_access(input logic write, input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] filter, input logic [1:0] order,
                           input logic dbl);
    cfg_access(1'b1, REG_FILTER, {30'b0, filter});
    cfg_access(1'b1, REG_ORDER, {30'b0, order});
    cfg_access(1'b1, REG_DOUBLE, {31'b0, dbl});
    cfg_access(1'b0, REG_FILTER, '0);
    cfg_access(1'b0, REG_ORDER, '0);
    cfg_access(1'b0, REG_DOUBLE, '0);
  endtask

  // Drain all pending and expected items, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int target;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady      = 1'b0;
    errors      = 0;
    item_count  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: keep all, arrival order, no doubling
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h0000_0001, 1'b1);
    wait_idle();
    cfg_access(1'b0, REG_FILTER, '0);
    cfg_access(1'b0, REG_ORDER, '0);
    cfg_access(1'b0, REG_DOUBLE, '0);

    // nonzero even, ascending, doubled: zero and odd values drop out
    configure(FILT_EVEN, ORD_ASC, 1'b1);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0002, 1'b0);
    add_item(32'hFFFF_FFFE, 1'b0);
    add_item(32'h0000_0003, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7FFF_FFFE, 1'b1);
    wait_idle();

    // odd, descending; the closing item itself is filtered out
    configure(FILT_ODD, ORD_DESC, 1'b1);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0001, 1'b0);
    add_item(32'h0000_0004, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h0000_0000, 1'b1);
    wait_idle();

    // run where nothing is kept: no results at all
    add_item(32'h0000_0002, 1'b0);
    add_item(32'h0000_0004, 1'b1);
    wait_idle();

    // unused filter and order codes act as defaults; spare index is ignored
    configure(FILT_SPARE, ORD_SPARE, 1'b1);
    cfg_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
    cfg_access(1'b0, REG_FILTER, '0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b1);
    add_item(32'h0000_0009, 1'b1);
    wait_idle();

    // random phases; a run left open carries into the next setting
    target = item_count + RANDOM_ITEMS;
    phase = 0;
    while (item_count < target) begin
      steady = (phase == 3 || phase == 4);
      if (phase == 1)
        configure(FILT_ALL, 2'($urandom_range(3)), 1'($urandom_range(1)));
      else
        configure(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      if ($urandom_range(3) == 0)
        cfg_access(1'b1, REG_SPARE, $urandom);
      // overfill the store at least once
      if (phase == 1)
        queue_run(70, 1'b1);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(7) == 0)
          queue_run($urandom_range(60, 72), 1'b1);
        else
          queue_run($urandom_range(1, 12), 1'b1);
      end
      if ($urandom_range(3) == 0)
        queue_run($urandom_range(1, 8), 1'b0);
      wait_idle();
      phase++;
    end
    steady = 1'b0;
    queue_run($urandom_range(1, 4), 1'b1);
    wait_idle();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
